// ===== src/scp_pkg.sv =====
// Types and constants shared by the stepper column positioner modules.
package scp_pkg;

	localparam int unsigned OFFSET_W = 10;
	localparam int unsigned PITCH_W  = 10;
	localparam int unsigned POS_W    = 14;
	localparam int unsigned BUDGET_W = 15;
	localparam int unsigned COL_W    = 4;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned DIV_STEPS = POS_W;
	localparam int unsigned PITCH_RESET  = 170;
	localparam int unsigned OFFSET_RESET = 20;
	localparam logic [COL_W-1:0] COL_NONE = 4'd15;

	typedef enum logic [2:0] {
		REQ_TICK          = 3'd0,
		REQ_MOVE          = 3'd1,
		REQ_HOME_PRESSED  = 3'd2,
		REQ_HOME_RELEASED = 3'd3,
		REQ_OTHER_KEY     = 3'd4,
		REQ_FORGET_HOME   = 3'd5
	} req_code_t;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_BUSY        = 3'd1,
		ST_ARRIVED     = 3'd2,
		ST_REJECTED    = 3'd3,
		ST_NOHOME      = 3'd4,
		ST_INTERRUPTED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_HOMING = 2'd1,
		MODE_MOVING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CS_IDLE    = 2'd0,
		CS_PREP    = 2'd1,
		CS_DIVIDE  = 2'd2,
		CS_PUBLISH = 2'd3
	} ctrl_state_t;

	typedef enum logic {
		CFG_COLUMN0_OFFSET = 1'b0,
		CFG_COLUMN_PITCH   = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [COL_W-1:0] target_column;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       step_pulse;
		logic             step_dir;
		logic [2:0]       status;
		logic             homed;
		logic [POS_W-1:0] position;
		logic [COL_W-1:0] aligned_column;
		logic [COL_W-1:0] closest_column;
	} out_item_t;

	typedef struct packed {
		logic update;
		logic prep;
		logic step;
		logic publish;
	} scp_cmd_t;

	typedef struct packed {
		logic div_last;
	} scp_sts_t;

endpackage

// ===== src/scp_datapath.sv =====
// Positioner state, configuration registers, column divider and result register.
module scp_datapath #(
	parameter int unsigned NUM_COLUMNS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scp_pkg::scp_cmd_t             cmd,
	output scp_pkg::scp_sts_t             sts,
	input  scp_pkg::in_item_t             in_data,
	output scp_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  scp_pkg::cfg_index_t           cfg_index,
	input  logic [scp_pkg::PITCH_W-1:0]   cfg_data
);

	localparam logic [scp_pkg::POS_W-1:0]    NCOL_POS  = scp_pkg::POS_W'(NUM_COLUMNS);
	localparam logic [scp_pkg::BUDGET_W-1:0] NCOL_BUD  = scp_pkg::BUDGET_W'(NUM_COLUMNS);
	localparam logic [scp_pkg::COL_W-1:0]    NCOL_COL  = scp_pkg::COL_W'(NUM_COLUMNS);
	localparam logic [scp_pkg::BUDGET_W-1:0] LAST_COL  = scp_pkg::BUDGET_W'(NUM_COLUMNS - 1);

	logic [scp_pkg::OFFSET_W-1:0] offset_q;
	logic [scp_pkg::PITCH_W-1:0]  pitch_q;
	scp_pkg::mode_t               mode_q, mode_d;
	logic [scp_pkg::POS_W-1:0]    pos_q, pos_d, target_q, target_d;
	logic                         homed_q, homed_d;
	logic [scp_pkg::BUDGET_W-1:0] budget_q, budget_d;

	logic [1:0]                   pulse_q, pulse_d;
	logic                         dir_q, dir_d;
	scp_pkg::status_t             status_q, status_d;

	logic                         in_range_q;
	logic [scp_pkg::PITCH_W-1:0]  rem_q;
	logic [scp_pkg::POS_W-1:0]    quo_q, dvd_q;
	logic [scp_pkg::CNT_W-1:0]    cnt_q;
	scp_pkg::out_item_t           out_q;

	// next-state logic of the positioner for one item
	always_comb begin
		logic [scp_pkg::POS_W-1:0]    new_target;
		logic [scp_pkg::BUDGET_W-1:0] new_budget, spent;
		logic [scp_pkg::POS_W-1:0]    stepped;
		new_target = {4'd0, offset_q}
			+ ({4'd0, pitch_q} * {10'd0, in_data.target_column});
		new_budget = {4'd0, offset_q, 1'b0} + ({5'd0, pitch_q} * NCOL_BUD);
		spent      = (budget_q >= 15'd2) ? budget_q - 15'd2 : '0;
		stepped    = (pos_q < target_q) ? pos_q + 14'd1 : pos_q - 14'd1;
		mode_d   = mode_q;
		pos_d    = pos_q;
		target_d = target_q;
		homed_d  = homed_q;
		budget_d = budget_q;
		pulse_d  = 2'd0;
		dir_d    = 1'b0;
		status_d = scp_pkg::ST_IDLE;
		unique case (in_data.req_type) inside
			scp_pkg::REQ_MOVE: begin
				if (in_data.target_column >= NCOL_COL) begin
					status_d = scp_pkg::ST_REJECTED;
				end else begin
					target_d = new_target;
					if (homed_q) begin
						mode_d   = (pos_q == new_target) ? scp_pkg::MODE_IDLE
							: scp_pkg::MODE_MOVING;
						status_d = (pos_q == new_target) ? scp_pkg::ST_ARRIVED
							: scp_pkg::ST_BUSY;
					end else begin
						budget_d = new_budget;
						mode_d   = scp_pkg::MODE_HOMING;
						status_d = scp_pkg::ST_BUSY;
					end
				end
			end
			scp_pkg::REQ_FORGET_HOME: begin
				status_d = (mode_q != scp_pkg::MODE_IDLE) ? scp_pkg::ST_INTERRUPTED
					: scp_pkg::ST_IDLE;
				mode_d   = scp_pkg::MODE_IDLE;
				homed_d  = 1'b0;
				pos_d    = '0;
			end
			scp_pkg::REQ_HOME_PRESSED, scp_pkg::REQ_HOME_RELEASED,
			scp_pkg::REQ_OTHER_KEY: begin
				case (mode_q)
					scp_pkg::MODE_HOMING: begin
						if (in_data.req_type == scp_pkg::REQ_HOME_PRESSED) begin
							pos_d    = '0;
							homed_d  = 1'b1;
							mode_d   = (target_q == '0) ? scp_pkg::MODE_IDLE
								: scp_pkg::MODE_MOVING;
							status_d = (target_q == '0) ? scp_pkg::ST_ARRIVED
								: scp_pkg::ST_BUSY;
						end else begin
							mode_d   = scp_pkg::MODE_IDLE;
							status_d = scp_pkg::ST_INTERRUPTED;
						end
					end
					scp_pkg::MODE_MOVING: begin
						// home release mid-move is ignored
						if (in_data.req_type == scp_pkg::REQ_HOME_RELEASED) begin
							status_d = scp_pkg::ST_BUSY;
						end else begin
							mode_d   = scp_pkg::MODE_IDLE;
							status_d = scp_pkg::ST_INTERRUPTED;
						end
					end
					default: ;
				endcase
			end
			default: begin
				// tick, and unknown codes act as one
				case (mode_q)
					scp_pkg::MODE_HOMING: begin
						if (budget_q == '0) begin
							mode_d   = scp_pkg::MODE_IDLE;
							status_d = scp_pkg::ST_NOHOME;
						end else begin
							pulse_d  = 2'd2;
							budget_d = spent;
							mode_d   = (spent == '0) ? scp_pkg::MODE_IDLE
								: scp_pkg::MODE_HOMING;
							status_d = (spent == '0) ? scp_pkg::ST_NOHOME
								: scp_pkg::ST_BUSY;
						end
					end
					scp_pkg::MODE_MOVING: begin
						pulse_d  = 2'd1;
						dir_d    = (pos_q < target_q);
						pos_d    = stepped;
						mode_d   = (stepped == target_q) ? scp_pkg::MODE_IDLE
							: scp_pkg::MODE_MOVING;
						status_d = (stepped == target_q) ? scp_pkg::ST_ARRIVED
							: scp_pkg::ST_BUSY;
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= scp_pkg::OFFSET_W'(scp_pkg::OFFSET_RESET);
			pitch_q  <= scp_pkg::PITCH_W'(scp_pkg::PITCH_RESET);
			mode_q   <= scp_pkg::MODE_IDLE;
			pos_q    <= '0;
			target_q <= '0;
			homed_q  <= 1'b0;
			budget_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == scp_pkg::CFG_COLUMN0_OFFSET) begin
					offset_q <= cfg_data;
				end else begin
					// a zero pitch behaves as one
					pitch_q <= (cfg_data == '0) ? scp_pkg::PITCH_W'(1) : cfg_data;
				end
			end
			if (cmd.update) begin
				mode_q   <= mode_d;
				pos_q    <= pos_d;
				target_q <= target_d;
				homed_q  <= homed_d;
				budget_q <= budget_d;
			end
		end
	end

	// item results and restoring divider for the column outputs
	always_ff @(posedge clk) begin
		logic [scp_pkg::PITCH_W:0] trial;
		trial = {rem_q, dvd_q[scp_pkg::POS_W-1]};
		if (cmd.update) begin
			pulse_q  <= pulse_d;
			dir_q    <= dir_d;
			status_q <= status_d;
		end
		if (cmd.prep) begin
			in_range_q <= homed_q && (pos_q >= {4'd0, offset_q});
			dvd_q      <= pos_q - {4'd0, offset_q};
			rem_q      <= '0;
			quo_q      <= '0;
			cnt_q      <= scp_pkg::CNT_W'(scp_pkg::DIV_STEPS - 1);
		end else if (cmd.step) begin
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q - scp_pkg::CNT_W'(1);
			if (trial >= {1'b0, pitch_q}) begin
				rem_q <= scp_pkg::PITCH_W'(trial - {1'b0, pitch_q});
				quo_q <= {quo_q[scp_pkg::POS_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[scp_pkg::PITCH_W-1:0];
				quo_q <= {quo_q[scp_pkg::POS_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [scp_pkg::BUDGET_W-1:0] rounded;
		rounded = {1'b0, quo_q} + ((rem_q > (pitch_q >> 1)) ? 15'd1 : 15'd0);
		if (cmd.publish) begin
			out_q.step_pulse <= pulse_q;
			out_q.step_dir   <= dir_q;
			out_q.status     <= status_q;
			out_q.homed      <= homed_q;
			out_q.position   <= homed_q ? pos_q : '0;
			if (in_range_q && rem_q == '0 && quo_q < NCOL_POS) begin
				out_q.aligned_column <= quo_q[scp_pkg::COL_W-1:0];
			end else begin
				out_q.aligned_column <= scp_pkg::COL_NONE;
			end
			if (!in_range_q) begin
				out_q.closest_column <= '0;
			end else if (rounded > LAST_COL) begin
				out_q.closest_column <= LAST_COL[scp_pkg::COL_W-1:0];
			end else begin
				out_q.closest_column <= rounded[scp_pkg::COL_W-1:0];
			end
		end
	end

	assign sts.div_last = (cnt_q == '0);
	assign out_data     = out_q;

endmodule

// ===== src/scp_ctrl.sv =====
// Sequencing state machine and output valid for the stepper column positioner.
module scp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  scp_pkg::scp_sts_t  sts,
	output scp_pkg::scp_cmd_t  cmd
);

	scp_pkg::ctrl_state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scp_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.update  = 1'b0;
		cmd.prep    = 1'b0;
		cmd.step    = 1'b0;
		cmd.publish = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			scp_pkg::CS_IDLE: begin
				in_stall   = 1'b0;
				cmd.update = in_valid;
				if (in_valid) begin
					state_d = scp_pkg::CS_PREP;
				end
			end
			scp_pkg::CS_PREP: begin
				cmd.prep = 1'b1;
				state_d  = scp_pkg::CS_DIVIDE;
			end
			scp_pkg::CS_DIVIDE: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = scp_pkg::CS_PUBLISH;
				end
			end
			scp_pkg::CS_PUBLISH: begin
				// hold until the result register is free
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = scp_pkg::CS_IDLE;
				end
			end
			default: state_d = scp_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == scp_pkg::CS_PREP)
		else $error("accepted item did not start preparation");

	a_prep_divide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scp_pkg::CS_PREP |=> state_q == scp_pkg::CS_DIVIDE)
		else $error("preparation not followed by division");

	a_publish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scp_pkg::CS_PUBLISH && out_valid_q && out_stall)
		|=> state_q == scp_pkg::CS_PUBLISH && out_valid_q)
		else $error("result published over a stalled item");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == scp_pkg::CS_PUBLISH))
		else $error("output valid raised outside publish");

endmodule

// ===== src/stepper_column_positioner.sv =====
// Top level of the stepper column positioner.
// Usage:
//   Input items (req_type, target_column) arrive on in_valid/in_stall and are
//   taken at an edge with in_valid high and in_stall low. Each item gives
//   exactly one result item on out_valid/out_stall with step count, direction,
//   status, homed flag, position and the aligned and closest columns.
//   Configuration (column0_offset at index 0, column_pitch at index 1) is
//   written on cfg_valid/cfg_ready; cfg_ready is always high. The user must
//   write it only while no item is in flight; the block does not enforce this.
//   Sequence: an accepted item passes a preparation step, the 14-step
//   restoring divider that turns position into column numbers (one quotient
//   bit a cycle) and a publish step that raises the result valid; no new item
//   is taken before the previous one is published.
//   The result sits in an output register, so a new item is taken while a
//   stalled result waits; a finished item then holds in the publish step
//   until that register frees up.
//   Reset clears the carriage state (not homed, position zero, idle) and
//   loads the registers with offset 20 and pitch 170.
module stepper_column_positioner #(
	parameter int unsigned NUM_COLUMNS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  scp_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output scp_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  scp_pkg::cfg_index_t           cfg_index,
	input  logic [scp_pkg::PITCH_W-1:0]   cfg_data
);

	scp_pkg::scp_cmd_t cmd;
	scp_pkg::scp_sts_t sts;

	assign cfg_ready = 1'b1;

	scp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	scp_datapath #(
		.NUM_COLUMNS (NUM_COLUMNS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
